FILE: rtl/core/bthin_pkg.sv
// Shared types, constants and the pixel deletion test for the thinning block.
// No dependencies; used by every module under rtl/core except bthin_ram.
package bthin_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DIM_W    = 7;
  localparam int CNT_W    = 13;
  localparam logic [CNT_W-1:0] PASS_MAX = {CNT_W{1'b1}};
  localparam int BLACK_MIN = 2;
  localparam int BLACK_MAX = 6;
  localparam int NBR_N     = 8;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_THIN  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_ITEM_RD,
    S_ITEM_EX,
    S_T_RD0,
    S_T_RD1,
    S_T_RD2,
    S_T_RUN,
    S_T_END,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    RD_ITEM,
    RD_ROW0,
    RD_ROW1,
    RD_ROW2,
    RD_AHEAD
  } rd_sel_t;

  typedef struct packed {
    logic    clr_wr;
    logic    latch;
    logic    exec;
    logic    thin_init;
    logic    sub_init;
    logic    shift;
    logic    run_step;
    logic    sub_end;
    logic    resp_load;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    kind_t kind;
    logic  small_img;
    logic  last_row;
    logic  phase;
    logic  change;
    logic  out_free;
  } status_t;

  // p[0..7] = P2..P9 (N, NE, E, SE, S, SW, W, NW)
  function automatic logic del_ok(input logic [NBR_N-1:0] p, input logic ph);
    logic [3:0] black;
    logic [3:0] trans;
    logic       rule;
    black = '0;
    trans = '0;
    for (int i = 0; i < NBR_N; i++) begin
      black = black + 4'(p[i]);
      if (!p[i] && p[(i == NBR_N - 1) ? 0 : i + 1]) begin
        trans = trans + 4'd1;
      end
    end
    if (!ph) begin
      rule = !(p[0] & p[2] & p[4]) && !(p[2] & p[4] & p[6]);
    end else begin
      rule = !(p[0] & p[2] & p[6]) && !(p[0] & p[4] & p[6]);
    end
    return (black >= 4'(BLACK_MIN)) && (black <= 4'(BLACK_MAX)) &&
           (trans == 4'd1) && rule;
  endfunction

endpackage

FILE: rtl/core/bthin_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bthin_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bthin_ctrl.sv
// Sequencer for the thinning block: clearing pass, item handling, thinning passes.
// Depends on bthin_pkg; drives bthin_dp through cmd_t / status_t.
module bthin_ctrl import bthin_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:     if (st.clr_last) state_nxt = S_IDLE;
      S_IDLE:    if (in_valid) state_nxt = S_ITEM_RD;
      S_ITEM_RD: begin
        if (st.kind == KIND_THIN) begin
          state_nxt = st.small_img ? S_T_END : S_T_RD0;
        end else begin
          state_nxt = S_ITEM_EX;
        end
      end
      S_ITEM_EX: state_nxt = S_RESP;
      S_T_RD0:   state_nxt = S_T_RD1;
      S_T_RD1:   state_nxt = S_T_RD2;
      S_T_RD2:   state_nxt = S_T_RUN;
      S_T_RUN:   if (st.last_row) state_nxt = S_T_END;
      S_T_END: begin
        if (!st.phase) begin
          state_nxt = st.small_img ? S_T_END : S_T_RD0;
        end else if (st.change) begin
          state_nxt = S_T_RD0;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP:    if (st.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_ITEM;
    in_ready   = 1'b0;
    case (state_r)
      S_CLR:     cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_ITEM_RD: cmd.thin_init = (st.kind == KIND_THIN);
      S_ITEM_EX: cmd.exec = 1'b1;
      S_T_RD0: begin
        cmd.rd_sel   = RD_ROW0;
        cmd.sub_init = 1'b1;
      end
      S_T_RD1: begin
        cmd.rd_sel = RD_ROW1;
        cmd.shift  = 1'b1;
      end
      S_T_RD2: begin
        cmd.rd_sel = RD_ROW2;
        cmd.shift  = 1'b1;
      end
      S_T_RUN: begin
        cmd.rd_sel   = RD_AHEAD;
        cmd.shift    = 1'b1;
        cmd.run_step = 1'b1;
      end
      S_T_END:   cmd.sub_end = 1'b1;
      S_RESP:    cmd.resp_load = st.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/bthin_dp.sv
// Datapath: row-wide image RAM, row window, 62 deletion lanes, counters, result register.
// Depends on bthin_pkg and bthin_ram; commanded by bthin_ctrl.
module bthin_dp import bthin_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            st,
  input  logic [DIM_W-1:0]   used_w,
  input  logic [DIM_W-1:0]   used_h,
  input  logic [1:0]         in_kind,
  input  logic [ROW_W-1:0]   in_row,
  input  logic [COL_W-1:0]   in_col,
  input  logic               in_pix,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_pix,
  output logic [CNT_W-1:0]   out_cnt
);

  kind_t               kind_r;
  logic [ROW_W-1:0]    item_row_r;
  logic [COL_W-1:0]    item_col_r;
  logic                item_pix_r;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic                phase_r, change_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                res_pix_r;
  logic                out_valid_r;
  logic                out_pix_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic [MAX_COLS-1:0] up_r, mid_r;

  logic                we;
  logic [ROW_W-1:0]    waddr, raddr;
  logic [MAX_COLS-1:0] wdata, rdata, row_mod, new_row;
  logic                in_img;

  bthin_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_img (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_img = ({1'b0, item_row_r} < used_h) && ({1'b0, item_col_r} < used_w);

  // deletion lanes; edge lanes can never be interior
  assign new_row[0]          = mid_r[0];
  assign new_row[MAX_COLS-1] = mid_r[MAX_COLS-1];
  for (genvar c = 1; c < MAX_COLS - 1; c++) begin : g_lane
    logic [NBR_N-1:0] nb;
    logic             interior;
    assign nb = {up_r[c-1], mid_r[c-1], rdata[c-1], rdata[c],
                 rdata[c+1], mid_r[c+1], up_r[c+1], up_r[c]};
    assign interior = (DIM_W'(c) + DIM_W'(2)) <= used_w;
    assign new_row[c] = mid_r[c] & ~(interior & del_ok(nb, phase_r));
  end

  always_comb begin
    row_mod             = rdata;
    row_mod[item_col_r] = item_pix_r;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_ITEM:  raddr = item_row_r;
      RD_ROW0:  raddr = ROW_W'(0);
      RD_ROW1:  raddr = ROW_W'(1);
      RD_ROW2:  raddr = ROW_W'(2);
      RD_AHEAD: raddr = ROW_W'(row_r + ROW_W'(2));
      default:  raddr = item_row_r;
    endcase
    we    = 1'b0;
    waddr = row_r;
    wdata = new_row;
    if (cmd.clr_wr) begin
      we    = 1'b1;
      wdata = '0;
    end else if (cmd.exec) begin
      we    = (kind_r == KIND_WRITE) && in_img;
      waddr = item_row_r;
      wdata = row_mod;
    end else if (cmd.run_step) begin
      we = 1'b1;
    end
  end

  always_comb begin
    row_nxt = row_r;
    if (cmd.clr_wr || cmd.run_step) begin
      row_nxt = row_r + ROW_W'(1);
    end else if (cmd.sub_init) begin
      row_nxt = ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      phase_r     <= 1'b0;
      change_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      if (cmd.thin_init) begin
        phase_r  <= 1'b0;
        change_r <= 1'b0;
        cnt_r    <= '0;
      end else if (cmd.run_step) begin
        change_r <= change_r | (|(mid_r & ~new_row));
      end else if (cmd.sub_end) begin
        phase_r <= ~phase_r;
        if (phase_r) begin
          change_r <= 1'b0;
          if (cnt_r != PASS_MAX) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
      end
      if (cmd.resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r     <= kind_t'(in_kind);
      item_row_r <= in_row;
      item_col_r <= in_col;
      item_pix_r <= in_pix;
    end
    if (cmd.exec) begin
      res_pix_r <= (kind_r == KIND_READ) && in_img && rdata[item_col_r];
    end
    if (cmd.shift) begin
      up_r  <= mid_r;
      mid_r <= rdata;
    end
    if (cmd.resp_load) begin
      out_pix_r <= (kind_r == KIND_READ) ? res_pix_r : 1'b0;
      out_cnt_r <= (kind_r == KIND_THIN) ? cnt_r : '0;
    end
  end

  assign st.clr_last  = (row_r == ROW_W'(MAX_ROWS - 1));
  assign st.kind      = kind_r;
  assign st.small_img = (used_h < DIM_W'(3)) || (used_w < DIM_W'(3));
  assign st.last_row  = ({1'b0, row_r} + DIM_W'(2)) == used_h;
  assign st.phase     = phase_r;
  assign st.change    = change_r;
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_cnt   = out_cnt_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_step |-> (row_r != '0) && (({1'b0, row_r} + DIM_W'(2)) <= used_h))
    else $error("thinning row out of range");
  a_cnt_nz: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_load && (kind_r == KIND_THIN) |=> (out_cnt_r != '0))
    else $error("thinning reported zero passes");

endmodule

FILE: rtl/core/binary_image_thinning.sv
// Top level of the binary image thinning block: config registers and stream ports.
// Depends on bthin_pkg, bthin_ctrl, bthin_dp (and bthin_ram through bthin_dp).
//
// Holds a 64 x 64 binary image, stored one 64-bit row per RAM word, and
// serves three request kinds on in_tuser: write a pixel, run Zhang-Suen
// thinning to convergence, read a pixel. Every request gives one result.
// After reset a clearing pass writes zeros to all 64 rows;
// in_tready stays low during it, config writes are taken as ever.
// Pixel writes and reads each go through accept, row read,
// read-modify-write or bit select, and result load. Thinning
// processes one row per cycle through a three-row window with 62
// parallel deletion lanes: each subiteration runs three row loads, h-2
// row updates and one wrap-up, and a pass is two subiterations, h being
// the rows in use; an image under 3 rows or columns takes one empty
// pass. A new request is accepted while a finished result still waits
// in the output register.
module binary_image_thinning import bthin_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // row_index[5:0], column_index[11:6], pixel_in[12]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pixel_out[0], pass_count[13:1]
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_WIDTH  = 1'b0;  // image_width at 0x0
  localparam logic REG_HEIGHT = 1'b1;  // image_height at 0x4

  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] used_w, used_h;
  logic             cfg_wr;
  logic             out_pix;
  logic [CNT_W-1:0] out_cnt;
  cmd_t             cmd;
  status_t          st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_COLS);
      height_r <= DIM_W'(MAX_ROWS);
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? {25'd0, height_r} : {25'd0, width_r};

  // registers above the array size act as the full size
  assign used_w = (width_r  > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : width_r;
  assign used_h = (height_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : height_r;

  bthin_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bthin_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .used_w    (used_w),
    .used_h    (used_h),
    .in_kind   (in_tuser),
    .in_row    (in_tdata[5:0]),
    .in_col    (in_tdata[11:6]),
    .in_pix    (in_tdata[12]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix),
    .out_cnt   (out_cnt)
  );

  assign out_tdata = {2'b00, out_cnt, out_pix};

endmodule
